@@ sv/assert_macros.svh @@
// Assertion macros used by the frustum culling RTL.
// Needs i_clk and the active-low reset i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frustum culling: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frustum culling: next-cycle check failed");

`endif

@@ sv/fbc_pkg.sv @@
// Types and constants of the frustum box culling core.
// No dependencies; every other file but assert_macros.svh imports this package.
`default_nettype none

package fbc_pkg;

    // fixed-point formats
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int VTX_W      = COORD_BITS + 1;   // centre plus or minus half size
    localparam int COMP_W     = COORD_BITS + 1;   // sum of two matrix elements
    localparam int PROD_W     = COMP_W + VTX_W;
    localparam int WTERM_W    = COMP_W + FRAC_BITS;
    localparam int SUM_W      = PROD_W + 2;       // three products plus the w term

    // field widths
    localparam int IDX_W   = 4;
    localparam int SEL_W   = 2;                   // row or column part of an index
    localparam int TAG_W   = 16;
    localparam int TOTAL_W = 17;

    // geometry
    localparam int AXES    = 3;
    localparam int MAT_DIM = 4;
    localparam int PLANES  = 6;
    localparam logic [SEL_W-1:0] W_SEL = 2'd3;    // row and column of the w terms

    // half size after reset: 1.5
    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(3) << (FRAC_BITS - 1);

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [VTX_W-1:0]      t_vtx;
    typedef logic signed [COMP_W-1:0]     t_comp;
    typedef logic signed [PROD_W-1:0]     t_prod;

    // word that travels down the row of plane cells
    typedef struct {
        logic               cmd;
        logic [IDX_W-1:0]   elem_index;
        t_coord             elem_value;
        t_vtx               vtx_hi [AXES];
        t_vtx               vtx_lo [AXES];
        logic [TAG_W-1:0]   tag;
        logic               vis;
    } t_word;

    // products held between the two halves of a cell
    typedef struct {
        t_prod                      prod [AXES];
        logic signed [WTERM_W-1:0]  wterm;
    } t_partial;

    // which plane a cell tests: row 3 plus or minus this row
    typedef struct packed {
        logic [SEL_W-1:0] row;
        logic             minus;
    } t_plane_sel;

endpackage

`default_nettype wire

@@ sv/fbc_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on fbc_pkg for field widths.
`default_nettype none

interface fbc_in_if import fbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [IDX_W-1:0] elem_index;
    t_coord           elem_value;
    t_coord           center_x;
    t_coord           center_y;
    t_coord           center_z;
    logic [TAG_W-1:0] object_tag;

    modport source (
        output valid, cmd, elem_index, elem_value, center_x, center_y, center_z, object_tag,
        input  ready
    );
    modport sink (
        input  valid, cmd, elem_index, elem_value, center_x, center_y, center_z, object_tag,
        output ready
    );
endinterface

interface fbc_out_if import fbc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               visible;
    logic [TAG_W-1:0]   result_tag;
    logic [TOTAL_W-1:0] visible_total;

    modport source (
        output valid, visible, result_tag, visible_total,
        input  ready
    );
    modport sink (
        input  valid, visible, result_tag, visible_total,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/fbc_front.sv @@
// Input stage: registers the input word and builds both box corners per axis.
// Holds the half-size register. Depends on fbc_pkg and fbc_in_if.
`default_nettype none

module fbc_front import fbc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [HALF_BITS-1:0] i_cfg_wr_data,
    fbc_in_if.sink               i_in,
    input  logic                 i_take,
    output logic                 o_valid,
    output t_word                o_word
);

    logic [HALF_BITS-1:0] r_half;
    logic                 r_valid;
    t_word                r_word;
    t_word                n_word;
    t_vtx                 w_half;
    t_coord               w_ctr [AXES];

    assign w_ctr[0] = i_in.center_x;
    assign w_ctr[1] = i_in.center_y;
    assign w_ctr[2] = i_in.center_z;
    assign w_half   = {2'b00, r_half};

    // accept while empty or while the word moves on
    assign i_in.ready = !r_valid || i_take;

    // build min and max corners
    always_comb begin
        n_word.cmd        = i_in.cmd;
        n_word.elem_index = i_in.elem_index;
        n_word.elem_value = i_in.elem_value;
        n_word.tag        = i_in.object_tag;
        n_word.vis        = 1'b1;
        for (int ax = 0; ax < AXES; ax++) begin
            n_word.vtx_hi[ax] = {w_ctr[ax][COORD_BITS-1], w_ctr[ax]} + w_half;
            n_word.vtx_lo[ax] = {w_ctr[ax][COORD_BITS-1], w_ctr[ax]} - w_half;
        end
    end

    // hold the half size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg_wr_en) begin
            r_half <= i_cfg_wr_data;
        end
    end

    // advance the stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // capture the word
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ sv/fbc_plane_cell.sv @@
// One plane cell: keeps its plane's matrix elements and components, multiplies
// in its first half and sums and tests the sign in its second. Depends on fbc_pkg.
`default_nettype none

module fbc_plane_cell import fbc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_plane_sel i_sel,
    input  logic       i_valid,
    input  t_word      i_word,
    output logic       o_take,
    output logic       o_valid,
    output t_word      o_word,
    input  logic       i_take
);

    // row i_sel.row and row 3 of each column, and the derived plane components
    t_coord   r_elem_row [MAT_DIM];
    t_coord   r_elem_w   [MAT_DIM];
    t_comp    r_comp     [MAT_DIM];

    logic     r_a_valid;
    t_word    r_a_word;
    logic     r_b_valid;
    t_word    r_b_word;
    t_partial r_b_part;
    t_partial n_b_part;

    logic              w_take_a;
    logic              w_take_b;
    logic              w_load;
    logic [SEL_W-1:0]  w_col;
    logic [SEL_W-1:0]  w_row;
    t_vtx              w_pick [AXES];
    logic signed [SUM_W-1:0] w_sum;

    function automatic t_comp plane_term(t_coord a_w, t_coord a_r, logic a_minus);
        t_comp ext_w;
        t_comp ext_r;
        ext_w = {a_w[COORD_BITS-1], a_w};
        ext_r = {a_r[COORD_BITS-1], a_r};
        return a_minus ? (ext_w - ext_r) : (ext_w + ext_r);
    endfunction

    assign w_take_b = !r_b_valid || i_take;
    assign w_take_a = !r_a_valid || w_take_b;
    assign o_take   = w_take_a;

    assign w_col  = r_a_word.elem_index[IDX_W-1 -: SEL_W];
    assign w_row  = r_a_word.elem_index[SEL_W-1:0];
    assign w_load = r_a_valid && (r_a_word.cmd == CMD_LOAD);

    // update plane elements when a load word sits here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAT_DIM; c++) begin
                r_elem_row[c] <= '0;
                r_elem_w[c]   <= '0;
                r_comp[c]     <= '0;
            end
        end else if (w_load) begin
            if (w_row == W_SEL) begin
                r_elem_w[w_col] <= r_a_word.elem_value;
                r_comp[w_col]   <= plane_term(r_a_word.elem_value, r_elem_row[w_col],
                                              i_sel.minus);
            end else if (w_row == i_sel.row) begin
                r_elem_row[w_col] <= r_a_word.elem_value;
                r_comp[w_col]     <= plane_term(r_elem_w[w_col], r_a_word.elem_value,
                                                i_sel.minus);
            end
        end
    end

    // pick the positive vertex and multiply
    always_comb begin
        for (int ax = 0; ax < AXES; ax++) begin
            w_pick[ax] = (!r_comp[ax][COMP_W-1] && (r_comp[ax] != '0)) ?
                         r_a_word.vtx_hi[ax] : r_a_word.vtx_lo[ax];
            n_b_part.prod[ax] = t_prod'(r_comp[ax]) * t_prod'(w_pick[ax]);
        end
        n_b_part.wterm = {r_comp[W_SEL], FRAC_BITS'(0)};
    end

    // first half: advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_take_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_a && i_valid) begin
            r_a_word <= i_word;
        end
    end

    // second half: advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_take_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_b && r_a_valid) begin
            r_b_word <= r_a_word;
            r_b_part <= n_b_part;
        end
    end

    // sum the distance and drop visibility on a negative one
    assign w_sum = SUM_W'(r_b_part.prod[0]) + SUM_W'(r_b_part.prod[1])
                 + SUM_W'(r_b_part.prod[2]) + SUM_W'(r_b_part.wterm);

    always_comb begin
        o_word     = r_b_word;
        o_word.vis = r_b_word.vis && !w_sum[SUM_W-1];
    end

    assign o_valid = r_b_valid;

endmodule

`default_nettype wire

@@ sv/fbc_tally.sv @@
// End of the row: counts visible objects, clears the count on loads and holds
// the result word for the output channel. Depends on fbc_pkg and fbc_out_if.
`default_nettype none

module fbc_tally import fbc_pkg::*; #(
    parameter int MAX_OBJECTS = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_word     i_word,
    output logic      o_take,
    fbc_out_if.source o_out
);

    localparam int CntW = $clog2(MAX_OBJECTS + 1);

    logic [CntW-1:0]         r_count;
    logic [CntW-1:0]         n_count;
    logic [CntW+TOTAL_W-1:0] w_total_ext;
    logic                    r_out_valid;
    logic                    r_vis;
    logic [TAG_W-1:0]        r_tag;
    logic [TOTAL_W-1:0]      r_total;
    logic                    w_arrive;
    logic                    w_test;

    // loads never occupy the output register
    assign o_take   = !i_valid || (i_word.cmd == CMD_LOAD) || !r_out_valid || o_out.ready;
    assign w_arrive = i_valid && o_take;
    assign w_test   = i_word.cmd == CMD_TEST;

    // clear on load, count visible tests up to the limit
    always_comb begin
        n_count = r_count;
        if (!w_test) begin
            n_count = '0;
        end else if (i_word.vis && (r_count < CntW'(MAX_OBJECTS))) begin
            n_count = r_count + 1'b1;
        end
    end

    assign w_total_ext = {{TOTAL_W{1'b0}}, n_count};

    // counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_arrive) begin
                r_count <= n_count;
            end
            if (w_arrive && w_test) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_arrive && w_test) begin
            r_vis   <= i_word.vis;
            r_tag   <= i_word.tag;
            r_total <= w_total_ext[TOTAL_W-1:0];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.visible       = r_vis;
    assign o_out.result_tag    = r_tag;
    assign o_out.visible_total = r_total;

endmodule

`default_nettype wire

@@ sv/frustum_box_culling_core.sv @@
// Top level of the frustum box culling core: input stage, row of six plane
// cells, tally stage. Depends on fbc_pkg, fbc_if, the three submodules and
// assert_macros.svh.
//
//   channel  dir  handshake        word
//   i_in     in   valid/ready      cmd, elem_index, elem_value, center_x/y/z, object_tag
//   o_out    out  valid/ready      visible, result_tag, visible_total
//   cfg      in   i_cfg_wr_en      i_cfg_wr_data = box_half_size
//
// One word per cycle while results are taken; a test word passes through the
// input stage, two stages in each of six plane cells and the output register.
// The row runs one 33x33 multiply per axis in each cell, then a four-term sum.
// Synchronous reset clears all valids, the matrix copies, the count, and sets
// the half size to 1.5. Bubbles collapse; input stalls only when the row is full
// behind a result word that is not taken. Load words pass even then at the end.
`default_nettype none

`include "assert_macros.svh"

module frustum_box_culling_core import fbc_pkg::*; #(
    parameter int MAX_OBJECTS = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [HALF_BITS-1:0] i_cfg_wr_data,
    fbc_in_if.sink               i_in,
    fbc_out_if.source            o_out
);

    logic       w_valid [PLANES+1];
    t_word      w_word  [PLANES+1];
    logic       w_take  [PLANES+1];
    t_plane_sel w_sel   [PLANES];

    // register input and build box corners
    fbc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_take        (w_take[0]),
        .o_valid       (w_valid[0]),
        .o_word        (w_word[0])
    );

    // one cell per plane: row 3 plus then minus rows 0, 1, 2
    for (genvar p = 0; p < PLANES; p++) begin : g_cell
        assign w_sel[p].row   = SEL_W'(p / 2);
        assign w_sel[p].minus = (p % 2) != 0;

        fbc_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sel   (w_sel[p]),
            .i_valid (w_valid[p]),
            .i_word  (w_word[p]),
            .o_take  (w_take[p]),
            .o_valid (w_valid[p+1]),
            .o_word  (w_word[p+1]),
            .i_take  (w_take[p+1])
        );
    end

    // count and present results
    fbc_tally #(
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[PLANES]),
        .i_word  (w_word[PLANES]),
        .o_take  (w_take[PLANES]),
        .o_out   (o_out)
    );

    // an accepted word lands in the input stage
    `ASSERT_NXT(a_accept_lands, i_in.valid && i_in.ready, w_valid[0])
    // the input side stalls only behind a result word that is not taken
    `ASSERT_IMP(a_stall_from_out, !i_in.ready, o_out.valid && !o_out.ready)
    // a load word reaching the end never raises a result
    `ASSERT_NXT(a_load_no_result,
        w_valid[PLANES] && (w_word[PLANES].cmd == CMD_LOAD) && !o_out.valid, !o_out.valid)

endmodule

`default_nettype wire
